// ===== rtl/core/tccf_pkg.sv =====
// Shared types and constants for the TCP client connection engine.
// Used by tccf_front, tccf_back and tcp_client_connection_fsm; depends on nothing.
package tccf_pkg;

  localparam int ENTRIES_DEFAULT = 4;
  localparam int PEER_CFG_REGS   = 4;
  localparam int QDEPTH          = 2;
  localparam int QPTR_W          = 1;
  localparam int QCNT_W          = 2;

  localparam logic [15:0] DEFAULT_LOCAL_PORT  = 16'd5517;
  localparam logic [15:0] DEFAULT_REMOTE_PORT = 16'd1883;
  localparam logic [15:0] DEFAULT_PEER_PORT   = 16'd1883;

  // Configuration register indexes.
  localparam logic [2:0] CFG_LOCAL_PORT  = 3'd0;
  localparam logic [2:0] CFG_REMOTE_PORT = 3'd1;
  localparam logic [2:0] CFG_PORT_COUNT  = 3'd2;
  localparam logic [2:0] CFG_PEER_PORT_0 = 3'd3;

  // TCP flag bits.
  localparam logic [7:0] F_FIN = 8'h01;
  localparam logic [7:0] F_SYN = 8'h02;
  localparam logic [7:0] F_PSH = 8'h08;
  localparam logic [7:0] F_ACK = 8'h10;

  typedef enum logic [1:0] {
    OP_SEGMENT    = 2'd0,
    OP_POLL       = 2'd1,
    OP_HS_TIMEOUT = 2'd2,
    OP_TW_TIMEOUT = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ENT_CLOSED          = 3'd0,
    ENT_SYN_WAITING     = 3'd1,
    ENT_ACK_PENDING     = 3'd2,
    ENT_ESTABLISHED     = 3'd3,
    ENT_FIN_ACK_PENDING = 3'd4,
    ENT_TIME_WAIT       = 3'd5
  } entry_state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  rx_flags;
    logic [31:0] rx_seq;
    logic [31:0] rx_ack;
    logic [15:0] ip_total_length;
    logic [3:0]  ip_header_words;
    logic [3:0]  tcp_header_words;
    logic [31:0] initial_seq;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  entry_index;
    logic [7:0]  tx_flags;
    logic [31:0] tx_seq;
    logic [31:0] tx_ack;
    logic [15:0] tx_src_port;
    logic [15:0] tx_dst_port;
    logic        last;
  } out_item_t;

  // Classified command handed from the front to the back.
  typedef struct packed {
    op_t         op;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic        fl_syn;
    logic        fl_ack;
    logic        fl_psh;
    logic        fl_fin;
    logic [31:0] rx_seq;
    logic [31:0] rx_ack;
    logic [15:0] payload;
    logic [31:0] initial_seq;
  } cmd_t;

endpackage

// ===== rtl/core/tccf_front.sv =====
// Front end: accepts input beats, decodes kind and flags, computes the payload size
// and queues the classified command for the back end. Depends on tccf_pkg.
module tccf_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tccf_pkg::in_item_t in_data,
  output logic               q_valid,
  input  logic               q_pop,
  output tccf_pkg::cmd_t     q_data
);
  import tccf_pkg::*;

  cmd_t              cmd_in;
  cmd_t              q_mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              push;

  always_comb begin
    cmd_in.op          = op_t'(in_data.kind);
    cmd_in.src_port    = in_data.src_port;
    cmd_in.dst_port    = in_data.dst_port;
    cmd_in.fl_syn      = |(in_data.rx_flags & F_SYN);
    cmd_in.fl_ack      = |(in_data.rx_flags & F_ACK);
    cmd_in.fl_psh      = |(in_data.rx_flags & F_PSH);
    cmd_in.fl_fin      = |(in_data.rx_flags & F_FIN);
    cmd_in.rx_seq      = in_data.rx_seq;
    cmd_in.rx_ack      = in_data.rx_ack;
    // Payload bytes wrap at 16 bits.
    cmd_in.payload     = in_data.ip_total_length
                       - {10'd0, in_data.ip_header_words, 2'b00}
                       - {10'd0, in_data.tcp_header_words, 2'b00};
    cmd_in.initial_seq = in_data.initial_seq;
  end

  assign in_ready = (count_r != QCNT_W'(QDEPTH));
  assign q_valid  = (count_r != '0);
  assign q_data   = q_mem[rd_ptr_r];
  assign push     = in_valid && in_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + QPTR_W'(1);
    end
    if (q_pop && q_valid) begin
      rd_ptr_nxt = rd_ptr_r + QPTR_W'(1);
    end
    if (push && !(q_pop && q_valid)) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (!push && q_pop && q_valid) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== rtl/core/tccf_back.sv =====
// Back end: holds configuration, the connection table and shared sequences, carries out
// queued commands and walks the table on a poll. Depends on tccf_pkg.
module tccf_back #(
  parameter int ENTRIES = tccf_pkg::ENTRIES_DEFAULT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_pop,
  input  tccf_pkg::cmd_t      q_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tccf_pkg::out_item_t out_data,
  input  logic                cfg_wr_en,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_wdata
);
  import tccf_pkg::*;

  localparam int IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CntW = $clog2(ENTRIES + 1);

  typedef enum logic [2:0] {
    BK_IDLE  = 3'b001,
    BK_WALK  = 3'b010,
    BK_FLUSH = 3'b100
  } back_state_t;

  back_state_t  state_r, state_nxt;
  logic [15:0]  local_port_r, local_port_nxt;
  logic [15:0]  remote_port_r, remote_port_nxt;
  logic [2:0]   port_count_r, port_count_nxt;
  logic [15:0]  peer_port_r [ENTRIES];
  logic [15:0]  peer_port_nxt [ENTRIES];
  entry_state_t ent_st_r [ENTRIES];
  entry_state_t ent_st_nxt [ENTRIES];
  logic [31:0]  cseq_r, cseq_nxt;
  logic [31:0]  sseq_r, sseq_nxt;
  logic [15:0]  payload_r, payload_nxt;
  logic         ack_due_r, ack_due_nxt;
  logic [IdxW-1:0] idx_r, idx_nxt;
  cmd_t         cur_r, cur_nxt;
  logic         hold_valid_r, hold_valid_nxt;
  out_item_t    hold_r, hold_nxt;
  logic         out_valid_r, out_valid_nxt;
  out_item_t    out_r, out_nxt;

  logic [4:0]      pc_ext;
  logic [4:0]      n_wide;
  logic [CntW-1:0] n_live;
  logic [IdxW-1:0] hit_idx;
  logic            hit_found;
  entry_state_t    hit_st;
  entry_state_t    walk_st;
  entry_state_t    want_st;
  logic            emit;
  logic [7:0]      emit_flags;
  logic [31:0]     emit_seq;
  logic            out_free;
  logic            last_step;

  assign pc_ext    = 5'(port_count_r);
  assign n_wide    = (pc_ext > 5'(ENTRIES)) ? 5'(ENTRIES) : pc_ext;
  assign n_live    = CntW'(n_wide);
  assign out_free  = !out_valid_r || out_ready;
  assign last_step = (CntW'(idx_r) + CntW'(1)) >= n_live;
  assign walk_st   = ent_st_r[idx_r];
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // First listed peer port that matches the segment's source port.
  always_comb begin
    hit_idx   = '0;
    hit_found = 1'b0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if ((CntW'(i) < n_live) && (peer_port_r[i] == q_data.src_port)) begin
        hit_idx   = IdxW'(i);
        hit_found = 1'b1;
      end
    end
  end

  assign hit_st = ent_st_r[hit_idx];

  // What the current walk entry sends, if anything.
  always_comb begin
    emit       = 1'b0;
    emit_flags = F_ACK;
    emit_seq   = cseq_r;
    case (walk_st)
      ENT_CLOSED: begin
        emit       = 1'b1;
        emit_flags = F_SYN;
        emit_seq   = cur_r.initial_seq;
      end
      ENT_ACK_PENDING: begin
        emit = 1'b1;
      end
      ENT_ESTABLISHED: begin
        emit = ack_due_r;
      end
      ENT_FIN_ACK_PENDING: begin
        emit       = ack_due_r;
        emit_flags = F_ACK | F_FIN;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt       = state_r;
    local_port_nxt  = local_port_r;
    remote_port_nxt = remote_port_r;
    port_count_nxt  = port_count_r;
    peer_port_nxt   = peer_port_r;
    ent_st_nxt      = ent_st_r;
    cseq_nxt        = cseq_r;
    sseq_nxt        = sseq_r;
    payload_nxt     = payload_r;
    ack_due_nxt     = ack_due_r;
    idx_nxt         = idx_r;
    cur_nxt         = cur_r;
    hold_valid_nxt  = hold_valid_r;
    hold_nxt        = hold_r;
    out_nxt         = out_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    q_pop           = 1'b0;
    want_st         = (q_data.op == OP_HS_TIMEOUT) ? ENT_SYN_WAITING : ENT_TIME_WAIT;

    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          cur_nxt = q_data;
          case (q_data.op)
            OP_SEGMENT: begin
              if ((q_data.dst_port == local_port_r) && hit_found) begin
                if (q_data.fl_syn && q_data.fl_ack && hit_st == ENT_SYN_WAITING) begin
                  ent_st_nxt[hit_idx] = ENT_ACK_PENDING;
                  cseq_nxt            = q_data.rx_ack;
                  sseq_nxt            = q_data.rx_seq + 32'd1;
                end else if (q_data.fl_ack && q_data.fl_psh &&
                             hit_st == ENT_ESTABLISHED) begin
                  cseq_nxt    = q_data.rx_ack;
                  sseq_nxt    = q_data.rx_seq;
                  ack_due_nxt = 1'b1;
                end else if (q_data.fl_ack && q_data.fl_fin) begin
                  ent_st_nxt[hit_idx] = ENT_FIN_ACK_PENDING;
                  cseq_nxt            = q_data.rx_ack;
                  sseq_nxt            = q_data.rx_seq + 32'd1;
                  ack_due_nxt         = 1'b1;
                end else if (q_data.fl_ack && hit_st == ENT_ESTABLISHED) begin
                  cseq_nxt = q_data.rx_ack;
                  sseq_nxt = q_data.rx_seq;
                end
                payload_nxt = q_data.payload;
              end
            end
            OP_POLL: begin
              // An empty table falls back to the default single peer.
              if (port_count_r == 3'd0) begin
                port_count_nxt   = 3'd1;
                peer_port_nxt[0] = DEFAULT_PEER_PORT;
                local_port_nxt   = DEFAULT_LOCAL_PORT;
                remote_port_nxt  = DEFAULT_REMOTE_PORT;
              end
              idx_nxt   = '0;
              state_nxt = BK_WALK;
            end
            default: begin
              for (int i = 0; i < ENTRIES; i++) begin
                if ((CntW'(i) < n_live) && (ent_st_r[i] == want_st)) begin
                  ent_st_nxt[i] = ENT_CLOSED;
                end
              end
            end
          endcase
        end
      end

      BK_WALK: begin
        if (!(emit && hold_valid_r && !out_free)) begin
          if (emit) begin
            case (walk_st)
              ENT_CLOSED: begin
                cseq_nxt          = cur_r.initial_seq;
                ent_st_nxt[idx_r] = ENT_SYN_WAITING;
              end
              ENT_ACK_PENDING: begin
                ent_st_nxt[idx_r] = ENT_ESTABLISHED;
              end
              ENT_FIN_ACK_PENDING: begin
                ent_st_nxt[idx_r] = ENT_TIME_WAIT;
                ack_due_nxt       = 1'b0;
              end
              default: begin
                ack_due_nxt = 1'b0;
              end
            endcase
            if (hold_valid_r) begin
              out_nxt       = hold_r;
              out_nxt.last  = 1'b0;
              out_valid_nxt = 1'b1;
            end
            hold_valid_nxt       = 1'b1;
            hold_nxt.entry_index = 2'(idx_r);
            hold_nxt.tx_flags    = emit_flags;
            hold_nxt.tx_seq      = emit_seq;
            hold_nxt.tx_ack      = sseq_r + {16'd0, payload_r};
            hold_nxt.tx_src_port = local_port_r;
            hold_nxt.tx_dst_port = remote_port_r;
            hold_nxt.last        = 1'b0;
          end
          if (last_step) begin
            state_nxt = BK_FLUSH;
          end else begin
            idx_nxt = idx_r + IdxW'(1);
          end
        end
      end

      BK_FLUSH: begin
        if (!hold_valid_r) begin
          state_nxt = BK_IDLE;
        end else if (out_free) begin
          out_nxt        = hold_r;
          out_nxt.last   = 1'b1;
          out_valid_nxt  = 1'b1;
          hold_valid_nxt = 1'b0;
          state_nxt      = BK_IDLE;
        end
      end

      default: begin
        state_nxt = BK_IDLE;
      end
    endcase

    if (cfg_wr_en) begin
      if (cfg_index == CFG_LOCAL_PORT) begin
        local_port_nxt = cfg_wdata;
      end
      if (cfg_index == CFG_REMOTE_PORT) begin
        remote_port_nxt = cfg_wdata;
      end
      if (cfg_index == CFG_PORT_COUNT) begin
        port_count_nxt = cfg_wdata[2:0];
      end
      for (int i = 0; i < ENTRIES; i++) begin
        if ((i < PEER_CFG_REGS) && (int'(cfg_index) == int'(CFG_PEER_PORT_0) + i)) begin
          peer_port_nxt[i] = cfg_wdata;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= BK_IDLE;
      local_port_r  <= DEFAULT_LOCAL_PORT;
      remote_port_r <= DEFAULT_REMOTE_PORT;
      port_count_r  <= 3'd0;
      for (int i = 0; i < ENTRIES; i++) begin
        peer_port_r[i] <= (i == 0) ? DEFAULT_PEER_PORT : 16'd0;
        ent_st_r[i]    <= ENT_CLOSED;
      end
      cseq_r        <= '0;
      sseq_r        <= '0;
      payload_r     <= '0;
      ack_due_r     <= 1'b0;
      idx_r         <= '0;
      hold_valid_r  <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      local_port_r  <= local_port_nxt;
      remote_port_r <= remote_port_nxt;
      port_count_r  <= port_count_nxt;
      peer_port_r   <= peer_port_nxt;
      ent_st_r      <= ent_st_nxt;
      cseq_r        <= cseq_nxt;
      sseq_r        <= sseq_nxt;
      payload_r     <= payload_nxt;
      ack_due_r     <= ack_due_nxt;
      idx_r         <= idx_nxt;
      hold_valid_r  <= hold_valid_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    hold_r <= hold_nxt;
    out_r  <= out_nxt;
  end

endmodule

// ===== rtl/core/tcp_client_connection_fsm.sv =====
// Top level of the TCP client connection engine: front end, command queue and back end.
// Depends on tccf_pkg, tccf_front and tccf_back.
//
// Usage: input beats (in_valid/in_ready/in_data) carry received segments, polls and
// the two timeout kinds. Only a poll produces result beats (out_valid/out_ready/
// out_data): one SYN, ACK or ACK|FIN per table entry that needs it, the final one
// flagged with last. Registers are written through cfg_wr_en/cfg_index/cfg_wdata;
// the user must write them only while the block is idle, which the block itself
// does not enforce; writes take effect on the next edge. A beat is first written
// into the front queue; segments and timeouts are carried out when the back end pops
// them from idle. A poll walks the n live entries (at most ENTRIES), visiting one
// table entry per cycle while the output is not stalled. Each result is held in the
// hold stage until the next result or the end of the walk shows whether it is the last,
// then moves to the output register. The two-entry queue keeps accepting beats
// while a poll walks. Reset (synchronous, active low) closes every entry, clears the
// sequences, payload size and ack-due flag, and restores register defaults. When the
// receiver stalls, one result waits on the output and one in the hold stage; the
// walk then pauses, and the queue fills before in_ready drops.
module tcp_client_connection_fsm #(
  parameter int ENTRIES = tccf_pkg::ENTRIES_DEFAULT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tccf_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tccf_pkg::out_item_t out_data,
  input  logic                cfg_wr_en,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_wdata
);
  import tccf_pkg::*;

  // Classified commands travel from the front to the back through the queue.
  logic q_valid;
  logic q_pop;
  cmd_t q_data;

  tccf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_data   (q_data)
  );

  // The back end owns all architectural state, including the registers, since a
  // poll on an empty table rewrites some of them.
  tccf_back #(
    .ENTRIES (ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_data    (q_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

endmodule

// ===== tb/sv/tccf_checker.sv =====
// Checker for the TCP client connection engine: watches the input, result and register ports,
// keeps its own copy of the connection table and compares every result beat in order.
// Depends on tccf_pkg for the payload structs, state codes, flag bits and register indexes.
module tccf_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  tccf_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  tccf_pkg::out_item_t out_data,
  input  logic                cfg_wr_en,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_wdata,
  output int                  mismatch_count,
  output int                  segs_outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import tccf_pkg::*;

  localparam int NENT = ENTRIES_DEFAULT;

  logic [15:0]  m_local;
  logic [15:0]  m_remote;
  logic [2:0]   m_count;
  logic [15:0]  m_peer [NENT];
  entry_state_t m_state [NENT];
  logic [31:0]  m_cseq;
  logic [31:0]  m_sseq;
  logic [15:0]  m_payload;
  logic         m_ack_due;

  // Segments the block is expected to send, oldest first.
  out_item_t    tx_seg_q [$];
  int           mismatches;

  initial begin
    mismatches = 0;
  end

  function automatic void clear_table();
    m_local   = DEFAULT_LOCAL_PORT;
    m_remote  = DEFAULT_REMOTE_PORT;
    m_count   = '0;
    for (int i = 0; i < NENT; i++) begin
      m_peer[i]  = '0;
      m_state[i] = ENT_CLOSED;
    end
    m_peer[0]  = DEFAULT_PEER_PORT;
    m_cseq     = '0;
    m_sseq     = '0;
    m_payload  = '0;
    m_ack_due  = 1'b0;
    tx_seg_q.delete();
  endfunction

  function automatic void write_register(logic [2:0] idx, logic [15:0] val);
    case (idx)
      CFG_LOCAL_PORT:  m_local  = val;
      CFG_REMOTE_PORT: m_remote = val;
      CFG_PORT_COUNT:  m_count  = val[2:0];
      default: begin
        if (idx >= CFG_PEER_PORT_0 && idx < CFG_PEER_PORT_0 + NENT)
          m_peer[idx - CFG_PEER_PORT_0] = val;
      end
    endcase
  endfunction

  function automatic int live_entries();
    return (m_count > NENT) ? NENT : int'(m_count);
  endfunction

  function automatic out_item_t tx_segment(int idx, logic [7:0] flags);
    out_item_t r;
    r.entry_index = 2'(idx);
    r.tx_flags    = flags;
    r.tx_seq      = m_cseq;
    r.tx_ack      = m_sseq + {16'h0000, m_payload};
    r.tx_src_port = m_local;
    r.tx_dst_port = m_remote;
    r.last        = 1'b0;
    return r;
  endfunction

  // Applies one accepted beat to the table and queues the segments that it makes the block send.
  function automatic void advance_connections(in_item_t it);
    out_item_t    batch [NENT];
    int           k;
    int           hit;
    int           live;
    logic         fl_ack;
    entry_state_t want;
    k   = 0;
    hit = -1;
    case (op_t'(it.kind))
      OP_SEGMENT: begin
        if (it.dst_port == m_local) begin
          live = live_entries();
          for (int i = 0; i < live; i++)
            if (hit < 0 && m_peer[i] == it.src_port) hit = i;
        end
        if (hit >= 0) begin
          fl_ack = (it.rx_flags & F_ACK) != 0;
          if ((it.rx_flags & F_SYN) != 0 && fl_ack && m_state[hit] == ENT_SYN_WAITING) begin
            m_state[hit] = ENT_ACK_PENDING;
            m_cseq       = it.rx_ack;
            m_sseq       = it.rx_seq + 32'd1;
          end else if (fl_ack && (it.rx_flags & F_PSH) != 0 &&
                       m_state[hit] == ENT_ESTABLISHED) begin
            m_cseq    = it.rx_ack;
            m_sseq    = it.rx_seq;
            m_ack_due = 1'b1;
          end else if (fl_ack && (it.rx_flags & F_FIN) != 0) begin
            m_cseq       = it.rx_ack;
            m_sseq       = it.rx_seq + 32'd1;
            m_state[hit] = ENT_FIN_ACK_PENDING;
            m_ack_due    = 1'b1;
          end else if (fl_ack && m_state[hit] == ENT_ESTABLISHED) begin
            m_cseq = it.rx_ack;
            m_sseq = it.rx_seq;
          end
          m_payload = it.ip_total_length - {10'd0, it.ip_header_words, 2'b00}
                      - {10'd0, it.tcp_header_words, 2'b00};
        end
      end
      OP_POLL: begin
        // A poll on an empty table first restores the default single connection.
        if (m_count == 0) begin
          m_peer[0] = DEFAULT_PEER_PORT;
          m_count   = 3'd1;
          m_remote  = DEFAULT_REMOTE_PORT;
          m_local   = DEFAULT_LOCAL_PORT;
        end
        live = live_entries();
        for (int i = 0; i < live; i++) begin
          case (m_state[i])
            ENT_CLOSED: begin
              m_cseq     = it.initial_seq;
              batch[k]   = tx_segment(i, F_SYN);
              k++;
              m_state[i] = ENT_SYN_WAITING;
            end
            ENT_ACK_PENDING: begin
              batch[k]   = tx_segment(i, F_ACK);
              k++;
              m_state[i] = ENT_ESTABLISHED;
            end
            ENT_ESTABLISHED: begin
              if (m_ack_due) begin
                batch[k]  = tx_segment(i, F_ACK);
                k++;
                m_ack_due = 1'b0;
              end
            end
            ENT_FIN_ACK_PENDING: begin
              if (m_ack_due) begin
                batch[k]   = tx_segment(i, F_ACK | F_FIN);
                k++;
                m_ack_due  = 1'b0;
                m_state[i] = ENT_TIME_WAIT;
              end
            end
            default: ;
          endcase
        end
        for (int j = 0; j < k; j++) begin
          if (j == k - 1) batch[j].last = 1'b1;
          tx_seg_q.push_back(batch[j]);
        end
      end
      default: begin
        want = (op_t'(it.kind) == OP_HS_TIMEOUT) ? ENT_SYN_WAITING : ENT_TIME_WAIT;
        live = live_entries();
        for (int i = 0; i < live; i++)
          if (m_state[i] == want) m_state[i] = ENT_CLOSED;
      end
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t exp_seg;
    if (!rst_n) begin
      clear_table();
    end else begin
      if (cfg_wr_en) write_register(cfg_index, cfg_wdata);
      if (out_valid && out_ready) begin
        if (tx_seg_q.size() == 0) begin
          $error("result beat with nothing expected: 0x%0h", out_data);
          mismatches++;
        end else begin
          exp_seg = tx_seg_q.pop_front();
          check_field("entry_index", 32'(exp_seg.entry_index), 32'(out_data.entry_index));
          check_field("tx_flags", 32'(exp_seg.tx_flags), 32'(out_data.tx_flags));
          check_field("tx_seq", exp_seg.tx_seq, out_data.tx_seq);
          check_field("tx_ack", exp_seg.tx_ack, out_data.tx_ack);
          check_field("tx_src_port", 32'(exp_seg.tx_src_port), 32'(out_data.tx_src_port));
          check_field("tx_dst_port", 32'(exp_seg.tx_dst_port), 32'(out_data.tx_dst_port));
          check_field("last", 32'(exp_seg.last), 32'(out_data.last));
        end
      end
      if (in_valid && in_ready) advance_connections(in_data);
    end
    mismatch_count   <= mismatches;
    segs_outstanding <= tx_seg_q.size();
  end

endmodule

// ===== tb/sv/tcp_client_connection_fsm_tb.sv =====
// Top of the testbench for the TCP client connection engine: clock, reset, stimulus and verdict.
// Depends on tccf_pkg, the block tcp_client_connection_fsm and the checker tccf_checker.
module tcp_client_connection_fsm_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tccf_pkg::*;

  // The run is far shorter than this; hitting it means the block hung.
  localparam int CYCLE_LIMIT = 400000;
  // Cycles left after the last expected result so that any segment or timeout still
  // in the queue and back end has settled before registers change or the run ends.
  localparam int IDLE_TAIL   = 24;
  localparam int PHASES      = 8;
  localparam int PHASE_BEATS = 56;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  int          mismatch_count;
  int          segs_outstanding;
  int          cycle_count = 0;
  int          stall_left  = 0;
  bit          quiet       = 1'b0;

  // The stimulus side keeps its own view of the registers so that it can aim segments
  // at the local port and at listed peer ports.
  logic [15:0] cfg_local  = DEFAULT_LOCAL_PORT;
  logic [15:0] cfg_remote = DEFAULT_REMOTE_PORT;
  logic [2:0]  cfg_count  = '0;
  logic [15:0] cfg_peer [ENTRIES_DEFAULT];
  logic [15:0] reg_plan [7];

  tcp_client_connection_fsm DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  tccf_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data          (in_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_data         (out_data),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .mismatch_count   (mismatch_count),
    .segs_outstanding (segs_outstanding)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // The receiver stalls in bursts of random length, except in the quiet last phase.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      out_ready  <= 1'b0;
      stall_left = $urandom_range(0, 3);
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    for (int i = 0; i < ENTRIES_DEFAULT; i++) cfg_peer[i] = '0;
    cfg_peer[0] = DEFAULT_PEER_PORT;
  end

  // Offers one beat and returns at the edge where it is taken. Valid is left high, so a
  // caller that has nothing more to send must lower it in the same time step.
  task automatic send_beat(input in_item_t item);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    // A poll on an empty table makes the block fall back to its default connection.
    if (item.kind == OP_POLL && cfg_count == 0) begin
      cfg_count   = 3'd1;
      cfg_peer[0] = DEFAULT_PEER_PORT;
      cfg_local   = DEFAULT_LOCAL_PORT;
      cfg_remote  = DEFAULT_REMOTE_PORT;
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stops the sender and waits until every expected result beat has come out and the
  // block has had time to finish any trailing segment or timeout.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (segs_outstanding != 0) @(posedge clk);
    repeat (IDLE_TAIL) @(posedge clk);
  endtask

  // Writes all seven registers from reg_plan on consecutive edges. Must be entered at an
  // edge while the block is idle.
  task automatic apply_reg_plan();
    for (int idx = 0; idx < 7; idx++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= 3'(idx);
      cfg_wdata <= reg_plan[idx];
      @(posedge clk);
    end
    cfg_wr_en  <= 1'b0;
    cfg_local  = reg_plan[CFG_LOCAL_PORT];
    cfg_remote = reg_plan[CFG_REMOTE_PORT];
    cfg_count  = reg_plan[CFG_PORT_COUNT][2:0];
    for (int i = 0; i < ENTRIES_DEFAULT; i++) cfg_peer[i] = reg_plan[CFG_PEER_PORT_0 + i];
  endtask

  // Poll or timeout beat; the segment fields are random and ignored by the block, but a poll uses the initial sequence.
  function automatic in_item_t ctl_beat(op_t op);
    in_item_t it;
    it.kind             = op;
    it.src_port         = 16'($urandom);
    it.dst_port         = 16'($urandom);
    it.rx_flags         = 8'($urandom);
    it.rx_seq           = $urandom;
    it.rx_ack           = $urandom;
    it.ip_total_length  = 16'($urandom);
    it.ip_header_words  = 4'($urandom);
    it.tcp_header_words = 4'($urandom);
    it.initial_seq      = $urandom;
    return it;
  endfunction

  function automatic in_item_t rx_segment(logic [15:0] src, logic [15:0] dst,
                                          logic [7:0] flags, logic [31:0] seq,
                                          logic [31:0] ack, logic [15:0] tot,
                                          logic [3:0] ihl, logic [3:0] doff);
    in_item_t it;
    it                  = ctl_beat(OP_SEGMENT);
    it.src_port         = src;
    it.dst_port         = dst;
    it.rx_flags         = flags;
    it.rx_seq           = seq;
    it.rx_ack           = ack;
    it.ip_total_length  = tot;
    it.ip_header_words  = ihl;
    it.tcp_header_words = doff;
    return it;
  endfunction

  // Random beat. Most segments are aimed at a live entry with one of the handshake flag
  // patterns, so that entries cycle through the whole connection life; the rest is noise.
  function automatic in_item_t random_beat();
    in_item_t it;
    int       r;
    int       live;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      it   = ctl_beat(OP_SEGMENT);
      live = (cfg_count > ENTRIES_DEFAULT) ? ENTRIES_DEFAULT : int'(cfg_count);
      if (live > 0 && $urandom_range(0, 9) < 8) begin
        it.dst_port = cfg_local;
        it.src_port = cfg_peer[$urandom_range(0, live - 1)];
        case ($urandom_range(0, 5))
          0, 1:    it.rx_flags = F_SYN | F_ACK;
          2:       it.rx_flags = F_PSH | F_ACK;
          3:       it.rx_flags = F_FIN | F_ACK;
          4:       it.rx_flags = F_ACK;
          default: it.rx_flags = 8'($urandom);
        endcase
        // Now and then add flag bits the block does not care about.
        if ($urandom_range(0, 7) == 0) it.rx_flags = it.rx_flags | (8'($urandom) & 8'hE4);
      end else if ($urandom_range(0, 1) == 0) begin
        it.dst_port = cfg_local;
      end
    end else if (r < 85) begin
      it = ctl_beat(OP_POLL);
    end else if (r < 93) begin
      it = ctl_beat(OP_HS_TIMEOUT);
    end else begin
      it = ctl_beat(OP_TW_TIMEOUT);
    end
    return it;
  endfunction

  initial begin
    in_item_t    it;
    logic [15:0] peer_a;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, starting from the register defaults with an empty table.
    // A segment before anything is listed is ignored.
    send_beat(rx_segment(DEFAULT_PEER_PORT, DEFAULT_LOCAL_PORT, F_SYN | F_ACK,
                         $urandom, $urandom, 16'd100, 4'd5, 4'd5));
    // The first poll restores the default entry and opens it with the largest initial sequence.
    it = ctl_beat(OP_POLL);
    it.initial_seq = 32'hFFFF_FFFF;
    send_beat(it);
    // SYN+ACK with the largest sequence, so the server sequence wraps, and the payload
    // size wraps below zero.
    send_beat(rx_segment(DEFAULT_PEER_PORT, DEFAULT_LOCAL_PORT, F_SYN | F_ACK,
                         32'hFFFF_FFFF, 32'h0000_0000, 16'h0000, 4'hF, 4'hF));
    send_beat(ctl_beat(OP_POLL));
    // Data push with the largest length and no headers.
    send_beat(rx_segment(DEFAULT_PEER_PORT, DEFAULT_LOCAL_PORT, F_PSH | F_ACK,
                         32'h0000_0000, 32'hFFFF_FFFF, 16'hFFFF, 4'h0, 4'h0));
    send_beat(ctl_beat(OP_POLL));
    send_beat(rx_segment(DEFAULT_PEER_PORT, DEFAULT_LOCAL_PORT, F_ACK,
                         $urandom, $urandom, 16'($urandom), 4'd5, 4'd8));
    // Wrong destination port, then a source port that is not listed: both are ignored.
    send_beat(rx_segment(DEFAULT_PEER_PORT, DEFAULT_LOCAL_PORT + 16'd1, F_FIN | F_ACK,
                         $urandom, $urandom, 16'd40, 4'd5, 4'd5));
    send_beat(rx_segment(DEFAULT_PEER_PORT + 16'd1, DEFAULT_LOCAL_PORT, F_FIN | F_ACK,
                         $urandom, $urandom, 16'd40, 4'd5, 4'd5));
    // No flags at all only updates the payload size; all flags act as a data push here.
    send_beat(rx_segment(DEFAULT_PEER_PORT, DEFAULT_LOCAL_PORT, 8'h00,
                         $urandom, $urandom, 16'd1500, 4'd5, 4'd5));
    send_beat(rx_segment(DEFAULT_PEER_PORT, DEFAULT_LOCAL_PORT, 8'hFF,
                         $urandom, $urandom, 16'd60, 4'd5, 4'd5));
    send_beat(ctl_beat(OP_POLL));
    // Peer closes; the poll answers with ACK|FIN and the entry sits in time-wait.
    send_beat(rx_segment(DEFAULT_PEER_PORT, DEFAULT_LOCAL_PORT, F_FIN | F_ACK,
                         $urandom, $urandom, 16'd52, 4'd5, 4'd8));
    send_beat(ctl_beat(OP_POLL));
    send_beat(ctl_beat(OP_POLL));
    send_beat(ctl_beat(OP_TW_TIMEOUT));
    send_beat(ctl_beat(OP_POLL));
    send_beat(ctl_beat(OP_HS_TIMEOUT));
    // A FIN on a closed entry still moves it to the FIN handshake.
    send_beat(rx_segment(DEFAULT_PEER_PORT, DEFAULT_LOCAL_PORT, F_FIN | F_ACK,
                         $urandom, $urandom, 16'd40, 4'd5, 4'd5));
    send_beat(ctl_beat(OP_POLL));
    send_beat(ctl_beat(OP_HS_TIMEOUT));
    send_beat(ctl_beat(OP_TW_TIMEOUT));
    drain_results();

    // Full table at the port extremes, with a duplicated peer port so the first match wins,
    // then one poll that opens all four closed entries.
    reg_plan[CFG_LOCAL_PORT]      = 16'hFFFF;
    reg_plan[CFG_REMOTE_PORT]     = 16'h0000;
    reg_plan[CFG_PORT_COUNT]      = 16'd4;
    reg_plan[CFG_PEER_PORT_0]     = 16'h0000;
    reg_plan[CFG_PEER_PORT_0 + 1] = 16'hFFFF;
    reg_plan[CFG_PEER_PORT_0 + 2] = DEFAULT_PEER_PORT;
    reg_plan[CFG_PEER_PORT_0 + 3] = 16'h0000;
    apply_reg_plan();
    send_beat(ctl_beat(OP_POLL));
    send_beat(rx_segment(16'h0000, 16'hFFFF, F_SYN | F_ACK,
                         $urandom, $urandom, 16'd40, 4'd5, 4'd5));
    send_beat(ctl_beat(OP_POLL));

    // Random phases, each with its own register setting. In the last one neither the sender
    // nor the receiver idles at random, though after a poll the sender may still drain results.
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      quiet = (ph == PHASES - 1);
      reg_plan[CFG_LOCAL_PORT]  = 16'($urandom);
      reg_plan[CFG_REMOTE_PORT] = 16'($urandom);
      for (int i = 0; i < ENTRIES_DEFAULT; i++) reg_plan[CFG_PEER_PORT_0 + i] = 16'($urandom);
      case (ph)
        0: begin
          reg_plan[CFG_LOCAL_PORT]  = DEFAULT_LOCAL_PORT;
          reg_plan[CFG_REMOTE_PORT] = DEFAULT_REMOTE_PORT;
          reg_plan[CFG_PORT_COUNT]  = 16'd1;
        end
        1: begin
          reg_plan[CFG_LOCAL_PORT]  = 16'h0000;
          reg_plan[CFG_REMOTE_PORT] = 16'hFFFF;
          reg_plan[CFG_PORT_COUNT]  = 16'd4;
        end
        2: begin
          // Count beyond the table, and two entries listening on the same peer port.
          reg_plan[CFG_LOCAL_PORT]      = 16'hFFFF;
          reg_plan[CFG_REMOTE_PORT]     = 16'h0000;
          reg_plan[CFG_PORT_COUNT]      = 16'd7;
          peer_a                        = reg_plan[CFG_PEER_PORT_0];
          reg_plan[CFG_PEER_PORT_0 + 2] = peer_a;
        end
        3:       reg_plan[CFG_PORT_COUNT] = 16'd0;
        4:       reg_plan[CFG_PORT_COUNT] = 16'd2;
        5: begin
          reg_plan[CFG_PORT_COUNT]      = 16'd3;
          reg_plan[CFG_PEER_PORT_0]     = 16'h0000;
          reg_plan[CFG_PEER_PORT_0 + 1] = 16'hFFFF;
        end
        6:       reg_plan[CFG_PORT_COUNT] = 16'd4;
        default: reg_plan[CFG_PORT_COUNT] = 16'd5;
      endcase
      apply_reg_plan();
      for (int n = 0; n < PHASE_BEATS; n++) begin
        it = random_beat();
        send_beat(it);
        // Occasionally hold the sender back until every pending result is out.
        if (it.kind == OP_POLL && $urandom_range(0, 19) == 0) drain_results();
      end
    end

    drain_results();
    if (mismatch_count == 0 && segs_outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
